@@ hw/rtl/csg_pkg.sv @@
// Shared types, codes and constants of the curvature speed governor.
package csg_pkg;

  localparam int unsigned MaxWindowDef = 1024;
  localparam int unsigned DataW = 16;
  localparam int unsigned OpW = 33;
  localparam int unsigned ResW = 34;
  localparam int unsigned QuoBits = 16;

  localparam logic [DataW-1:0] ScaleOne = 16'h8000;
  localparam logic [DataW-1:0] GainResetVal = 16'h8000;

  localparam logic [1:0] OP_POINT = 2'd0;
  localparam logic [1:0] OP_EMPTY = 2'd1;
  localparam logic [1:0] OP_CMD = 2'd2;
  localparam logic [1:0] OP_TICK = 2'd3;

  localparam logic [1:0] REG_WINDOW = 2'd0;
  localparam logic [1:0] REG_BRAKE_GAIN = 2'd1;
  localparam logic [1:0] REG_MIN_SCALE = 2'd2;
  localparam logic [1:0] REG_SMOOTH_GAIN = 2'd3;

  typedef enum logic [1:0] {
    UOP_ADD,
    UOP_SUB,
    UOP_MUL
  } unit_op_e;

  typedef struct packed {
    unit_op_e op;
    logic [OpW-1:0] a;
    logic [OpW-1:0] b;
  } unit_req_t;

  typedef struct packed {
    logic [ResW-1:0] res;
    logic ge;
  } unit_rsp_t;

endpackage

@@ hw/rtl/csg_unit.sv @@
// Shared arithmetic unit: add, compare-subtract and a 17 by 17 bit multiply.
module csg_unit (
  input  csg_pkg::unit_req_t req_i,
  output csg_pkg::unit_rsp_t rsp_o
);

  logic [csg_pkg::ResW-1:0] diff;

  assign diff = {1'b0, req_i.a} - {1'b0, req_i.b};

  always_comb begin
    rsp_o.ge = ~diff[csg_pkg::ResW-1];
    unique case (req_i.op)
      csg_pkg::UOP_ADD: rsp_o.res = {1'b0, req_i.a} + {1'b0, req_i.b};
      csg_pkg::UOP_SUB: rsp_o.res = diff;
      csg_pkg::UOP_MUL: rsp_o.res = req_i.a[16:0] * req_i.b[16:0];
      default: rsp_o.res = '0;
    endcase
  end

endmodule

@@ hw/rtl/curvature_speed_governor.sv @@
// Top level of the curvature speed governor: sequencer, state and result register.
//
// Profile points without the last flag, empty-profile requests and velocity
// commands are taken without raising the stall. A last profile point makes the
// block busy: a multiply and an add form the divisor, an add rounds the
// numerator, a 16-step restoring divide yields the target scale, and two
// multiplies and two adds run the scale filter. A publish tick with a command
// latched also makes it busy: two multiplies for the linear speeds, a 16-step
// square root of the scale, a rounding step and a multiply for the yaw rate; it
// waits at the end only while a previous result still sits unclaimed in the
// output register. These steps share one adder, subtractor and multiplier; the
// divide and the square root yield one quotient or root bit per cycle. A tick
// with no command latched leaves the block idle and gives no result.
module curvature_speed_governor #(
  parameter int unsigned MaxWindow = csg_pkg::MaxWindowDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic signed [15:0] curvature_i,
  input  logic        last_point_i,
  input  logic signed [15:0] vel_x_i,
  input  logic signed [15:0] vel_y_i,
  input  logic signed [15:0] yaw_rate_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [15:0] out_vel_x_o,
  output logic signed [15:0] out_vel_y_o,
  output logic signed [15:0] out_yaw_rate_o,
  output logic [15:0] speed_scale_o
);

  localparam int unsigned WinCap = (MaxWindow < 2047) ? MaxWindow : 2047;
  localparam int unsigned CountW = $clog2(WinCap + 1);
  localparam logic [3:0] IterLast = 4'(csg_pkg::QuoBits - 1);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_DEN_MUL = 5'd1;
  localparam logic [4:0] S_DEN_ADD = 5'd2;
  localparam logic [4:0] S_NUM_ADD = 5'd3;
  localparam logic [4:0] S_DIV = 5'd4;
  localparam logic [4:0] S_FLT_MUL1 = 5'd5;
  localparam logic [4:0] S_FLT_MUL2 = 5'd6;
  localparam logic [4:0] S_FLT_ADD = 5'd7;
  localparam logic [4:0] S_FLT_DONE = 5'd8;
  localparam logic [4:0] S_X_MUL = 5'd9;
  localparam logic [4:0] S_X_RND = 5'd10;
  localparam logic [4:0] S_Y_MUL = 5'd11;
  localparam logic [4:0] S_Y_RND = 5'd12;
  localparam logic [4:0] S_SQ = 5'd13;
  localparam logic [4:0] S_SQ_RND = 5'd14;
  localparam logic [4:0] S_W_MUL = 5'd15;
  localparam logic [4:0] S_W_RND = 5'd16;

  function automatic logic [15:0] mag16(input logic [15:0] v);
    mag16 = v[15] ? (~v) + 16'd1 : v;
  endfunction

  function automatic logic [15:0] round_mul(input logic [31:0] prod, input logic neg);
    logic [31:0] sum;
    logic [16:0] mag;
    sum = prod + 32'd16384;
    mag = sum[31:15];
    if (neg) begin
      round_mul = (mag > 17'd32768) ? 16'h8000 : 16'(17'd0 - mag);
    end else begin
      round_mul = (mag > 17'd32767) ? 16'h7FFF : mag[15:0];
    end
  endfunction

  logic [10:0] win_q;
  logic [15:0] gain_q, mins_q, sgain_q;
  logic [CountW-1:0] count_q, count_d;
  logic [15:0] peak_q, peak_d;
  logic [15:0] filt_q, filt_d;
  logic cmd_q, cmd_d;
  logic [4:0] state_q, state_d;
  logic [3:0] iter_q, iter_d;
  logic out_valid_q, out_valid_d;

  logic [15:0] hvx_q, hvx_d, hvy_q, hvy_d, hw_q, hw_d;
  logic [33:0] acc_q, acc_d;
  logic [31:0] den_q, den_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] sh_q, sh_d;
  logic [16:0] q_q, q_d;
  logic [15:0] ox_q, ox_d, oy_q, oy_d;
  logic [15:0] ovx_q, ovx_d, ovy_q, ovy_d, ow_q, ow_d, osc_q, osc_d;

  logic in_acc;
  logic [10:0] win_eff;
  logic [15:0] k_mag, gc, lo, q_clamp, tval;
  logic [32:0] div_trial, sq_trial, flt_sum;
  logic [17:0] flt_new;
  csg_pkg::unit_req_t ureq;
  csg_pkg::unit_rsp_t ursp;

  csg_unit u_unit (
    .req_i(ureq),
    .rsp_o(ursp)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_vel_x_o = ovx_q;
  assign out_vel_y_o = ovy_q;
  assign out_yaw_rate_o = ow_q;
  assign speed_scale_o = osc_q;

  always_comb begin
    if (win_q == 11'd0) begin
      win_eff = 11'd1;
    end else if ({21'b0, win_q} > 32'(WinCap)) begin
      win_eff = 11'(WinCap);
    end else begin
      win_eff = win_q;
    end
  end

  assign k_mag = mag16(curvature_i);
  assign gc = (sgain_q > csg_pkg::ScaleOne) ? csg_pkg::ScaleOne : sgain_q;
  assign lo = (mins_q > csg_pkg::ScaleOne) ? csg_pkg::ScaleOne : mins_q;
  assign q_clamp = (q_q > {1'b0, csg_pkg::ScaleOne}) ? csg_pkg::ScaleOne : q_q[15:0];
  assign tval = (q_clamp < lo) ? lo : q_clamp;
  assign div_trial = {rem_q[31:0], sh_q[31]};
  assign sq_trial = {rem_q[30:0], sh_q[31:30]};
  assign flt_sum = {1'b0, acc_q[31:0]} + 33'd16384;
  assign flt_new = flt_sum[32:15];

  always_comb begin
    ureq.op = csg_pkg::UOP_ADD;
    ureq.a = '0;
    ureq.b = '0;
    unique case (state_q)
      S_DEN_MUL: begin
        ureq.op = csg_pkg::UOP_MUL;
        ureq.a = {17'b0, gain_q};
        ureq.b = {17'b0, peak_q};
      end
      S_DEN_ADD: begin
        ureq.a = acc_q[32:0];
        ureq.b = 33'd65536;
      end
      S_NUM_ADD: begin
        ureq.a = 33'h080000000;
        ureq.b = {2'b0, den_q[31:1]};
      end
      S_DIV: begin
        ureq.op = csg_pkg::UOP_SUB;
        ureq.a = div_trial;
        ureq.b = {1'b0, den_q};
      end
      S_FLT_MUL1: begin
        ureq.op = csg_pkg::UOP_MUL;
        ureq.a = {17'b0, filt_q};
        ureq.b = {17'b0, csg_pkg::ScaleOne - gc};
      end
      S_FLT_MUL2: begin
        ureq.op = csg_pkg::UOP_MUL;
        ureq.a = {17'b0, tval};
        ureq.b = {17'b0, gc};
      end
      S_FLT_ADD: begin
        ureq.a = acc_q[32:0];
        ureq.b = rem_q;
      end
      S_X_MUL: begin
        ureq.op = csg_pkg::UOP_MUL;
        ureq.a = {17'b0, mag16(hvx_q)};
        ureq.b = {17'b0, filt_q};
      end
      S_Y_MUL: begin
        ureq.op = csg_pkg::UOP_MUL;
        ureq.a = {17'b0, mag16(hvy_q)};
        ureq.b = {17'b0, filt_q};
      end
      S_SQ: begin
        ureq.op = csg_pkg::UOP_SUB;
        ureq.a = sq_trial;
        ureq.b = {14'b0, q_q, 2'b01};
      end
      S_SQ_RND: begin
        ureq.op = csg_pkg::UOP_SUB;
        ureq.a = {16'b0, q_q};
        ureq.b = rem_q;
      end
      S_W_MUL: begin
        ureq.op = csg_pkg::UOP_MUL;
        ureq.a = {17'b0, mag16(hw_q)};
        ureq.b = {17'b0, q_clamp};
      end
      default: begin
        ureq.op = csg_pkg::UOP_ADD;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    iter_d = iter_q;
    count_d = count_q;
    peak_d = peak_q;
    filt_d = filt_q;
    cmd_d = cmd_q;
    hvx_d = hvx_q;
    hvy_d = hvy_q;
    hw_d = hw_q;
    acc_d = acc_q;
    den_d = den_q;
    rem_d = rem_q;
    sh_d = sh_q;
    q_d = q_q;
    ox_d = ox_q;
    oy_d = oy_q;
    ovx_d = ovx_q;
    ovy_d = ovy_q;
    ow_d = ow_q;
    osc_d = osc_q;
    out_valid_d = out_valid_q & out_stall_i;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (op_i)
            csg_pkg::OP_POINT: begin
              if (11'(count_q) < win_eff) begin
                count_d = count_q + 1'b1;
                if (k_mag > peak_q) begin
                  peak_d = k_mag;
                end
              end
              if (last_point_i) begin
                state_d = S_DEN_MUL;
              end
            end
            csg_pkg::OP_EMPTY: begin
              filt_d = csg_pkg::ScaleOne;
              count_d = '0;
              peak_d = '0;
            end
            csg_pkg::OP_CMD: begin
              hvx_d = vel_x_i;
              hvy_d = vel_y_i;
              hw_d = yaw_rate_i;
              cmd_d = 1'b1;
            end
            csg_pkg::OP_TICK: begin
              if (cmd_q) begin
                state_d = S_X_MUL;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_DEN_MUL: begin
        acc_d = ursp.res;
        count_d = '0;
        peak_d = '0;
        state_d = S_DEN_ADD;
      end
      S_DEN_ADD: begin
        den_d = ursp.res[31:0];
        state_d = S_NUM_ADD;
      end
      S_NUM_ADD: begin
        rem_d = {17'b0, ursp.res[31:16]};
        sh_d = {ursp.res[15:0], 16'b0};
        q_d = '0;
        iter_d = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        rem_d = ursp.ge ? {1'b0, ursp.res[31:0]} : div_trial;
        q_d = {q_q[15:0], ursp.ge};
        sh_d = {sh_q[30:0], 1'b0};
        iter_d = iter_q + 4'd1;
        if (iter_q == IterLast) begin
          state_d = S_FLT_MUL1;
        end
      end
      S_FLT_MUL1: begin
        acc_d = ursp.res;
        state_d = S_FLT_MUL2;
      end
      S_FLT_MUL2: begin
        rem_d = ursp.res[32:0];
        state_d = S_FLT_ADD;
      end
      S_FLT_ADD: begin
        acc_d = ursp.res;
        state_d = S_FLT_DONE;
      end
      S_FLT_DONE: begin
        filt_d = (flt_new > {2'b0, csg_pkg::ScaleOne}) ? csg_pkg::ScaleOne : flt_new[15:0];
        state_d = S_IDLE;
      end
      S_X_MUL: begin
        acc_d = ursp.res;
        state_d = S_X_RND;
      end
      S_X_RND: begin
        ox_d = round_mul(acc_q[31:0], hvx_q[15]);
        state_d = S_Y_MUL;
      end
      S_Y_MUL: begin
        acc_d = ursp.res;
        state_d = S_Y_RND;
      end
      S_Y_RND: begin
        oy_d = round_mul(acc_q[31:0], hvy_q[15]);
        sh_d = {1'b0, filt_q, 15'b0};
        rem_d = '0;
        q_d = '0;
        iter_d = '0;
        state_d = S_SQ;
      end
      S_SQ: begin
        rem_d = ursp.ge ? ursp.res[32:0] : sq_trial;
        q_d = {q_q[15:0], ursp.ge};
        sh_d = {sh_q[29:0], 2'b00};
        iter_d = iter_q + 4'd1;
        if (iter_q == IterLast) begin
          state_d = S_SQ_RND;
        end
      end
      S_SQ_RND: begin
        if (!ursp.ge) begin
          q_d = q_q + 17'd1;
        end
        state_d = S_W_MUL;
      end
      S_W_MUL: begin
        acc_d = ursp.res;
        state_d = S_W_RND;
      end
      S_W_RND: begin
        if (!out_valid_q || !out_stall_i) begin
          ovx_d = ox_q;
          ovy_d = oy_q;
          ow_d = round_mul(acc_q[31:0], hw_q[15]);
          osc_d = filt_q;
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= 11'd1;
      gain_q <= '0;
      mins_q <= '0;
      sgain_q <= csg_pkg::GainResetVal;
      state_q <= S_IDLE;
      iter_q <= '0;
      count_q <= '0;
      peak_q <= '0;
      filt_q <= csg_pkg::ScaleOne;
      cmd_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          csg_pkg::REG_WINDOW: win_q <= cfg_wdata_i[10:0];
          csg_pkg::REG_BRAKE_GAIN: gain_q <= cfg_wdata_i;
          csg_pkg::REG_MIN_SCALE: mins_q <= cfg_wdata_i;
          csg_pkg::REG_SMOOTH_GAIN: sgain_q <= cfg_wdata_i;
          default: win_q <= win_q;
        endcase
      end
      state_q <= state_d;
      iter_q <= iter_d;
      count_q <= count_d;
      peak_q <= peak_d;
      filt_q <= filt_d;
      cmd_q <= cmd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hvx_q <= hvx_d;
    hvy_q <= hvy_d;
    hw_q <= hw_d;
    acc_q <= acc_d;
    den_q <= den_d;
    rem_q <= rem_d;
    sh_q <= sh_d;
    q_q <= q_d;
    ox_q <= ox_d;
    oy_q <= oy_d;
    ovx_q <= ovx_d;
    ovy_q <= ovy_d;
    ow_q <= ow_d;
    osc_q <= osc_d;
  end

endmodule

@@ hw/rtl/csg_checker.sv @@
// Port-level assertions for the curvature speed governor and their bind.
module csg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [1:0]  op_i,
  input logic        last_point_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] out_vel_x_o,
  input logic [15:0] out_vel_y_o,
  input logic [15:0] out_yaw_rate_o,
  input logic [15:0] speed_scale_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_vel_x_o) &&
      $stable(out_vel_y_o) && $stable(out_yaw_rate_o) && $stable(speed_scale_o)))
    else $error("Stalled result changed or vanished.");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && op_i != csg_pkg::OP_TICK && !out_valid_o)
      |=> !out_valid_o)
    else $error("Result appeared without a publish tick.");

  a_profile_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && op_i == csg_pkg::OP_POINT && last_point_i)
      |=> in_stall_o)
    else $error("End of profile did not start the scale update.");

  a_scale_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (speed_scale_o <= csg_pkg::ScaleOne))
    else $error("Reported scale above one.");

endmodule

bind curvature_speed_governor csg_checker u_csg_checker (.*);

@@ bench/tb_top.sv @@
// Self-checking testbench of the curvature speed governor with directed and random requests.
`timescale 1ns / 1ps

module tb_top;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [15:0] curv;
    logic               last;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] w;
  } governor_req_t;

  typedef struct packed {
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] w;
    logic [15:0]        scale;
  } governed_cmd_t;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [15:0] curv;
    logic               last;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] w;
    logic               typed;
    logic signed [15:0] ex_vx;
    logic signed [15:0] ex_vy;
    logic signed [15:0] ex_w;
    logic [15:0]        ex_scale;
  } directed_row_t;

  typedef struct packed {
    logic [15:0] win;
    logic [15:0] brake;
    logic [15:0] floor;
    logic [15:0] smooth;
  } gov_settings_t;

  localparam int DirRows = 25;
  localparam int PartB = 8;
  localparam int NumPhases = 10;
  localparam int PhaseItems = 40;
  localparam int SettleCycles = 40;
  localparam int LongProfile = 1026;

  localparam directed_row_t DirTable [DirRows] = '{
    '{csg_pkg::OP_TICK,  16'sd0,      1'b0, 16'sd0,     16'sd0,      16'sd0,
      1'b0, 16'sd0, 16'sd0, 16'sd0, 16'd0},
    '{csg_pkg::OP_POINT, 16'sh7FFF,   1'b1, 16'sd0,     16'sd0,      16'sd0,
      1'b0, 16'sd0, 16'sd0, 16'sd0, 16'd0},
    '{csg_pkg::OP_CMD,   16'sd0,      1'b0, 16'sh7FFF,  16'sh8000,   16'sh1234,
      1'b0, 16'sd0, 16'sd0, 16'sd0, 16'd0},
    '{csg_pkg::OP_TICK,  16'sd0,      1'b0, 16'sd0,     16'sd0,      16'sd0,
      1'b1, 16'sh7FFF, 16'sh8000, 16'sh1234, 16'h8000},
    '{csg_pkg::OP_CMD,   16'sd0,      1'b0, -16'sd1,    16'sd1,      16'sh8000,
      1'b0, 16'sd0, 16'sd0, 16'sd0, 16'd0},
    '{csg_pkg::OP_TICK,  16'sd0,      1'b0, 16'sd0,     16'sd0,      16'sd0,
      1'b1, -16'sd1, 16'sd1, 16'sh8000, 16'h8000},
    '{csg_pkg::OP_EMPTY, 16'sd0,      1'b0, 16'sd0,     16'sd0,      16'sd0,
      1'b0, 16'sd0, 16'sd0, 16'sd0, 16'd0},
    '{csg_pkg::OP_TICK,  16'sd0,      1'b0, 16'sd0,     16'sd0,      16'sd0,
      1'b1, -16'sd1, 16'sd1, 16'sh8000, 16'h8000},
    '{csg_pkg::OP_CMD,   16'sd0,      1'b0, 16'sd256,   -16'sd256,   16'sd256,
      1'b0, 16'sd0, 16'sd0, 16'sd0, 16'd0},
    '{csg_pkg::OP_POINT, 16'sh8000,   1'b0, 16'sd0,     16'sd0,      16'sd0,
      1'b0, 16'sd0, 16'sd0, 16'sd0, 16'd0},
    '{csg_pkg::OP_POINT, 16'sd100,    1'b0, 16'sd0,     16'sd0,      16'sd0,
      1'b0, 16'sd0, 16'sd0, 16'sd0, 16'd0},
    '{csg_pkg::OP_POINT, 16'sd50,     1'b0, 16'sd0,     16'sd0,      16'sd0,
      1'b0, 16'sd0, 16'sd0, 16'sd0, 16'd0},
    '{csg_pkg::OP_POINT, 16'sh7FFF,   1'b1, 16'sd0,     16'sd0,      16'sd0,
      1'b0, 16'sd0, 16'sd0, 16'sd0, 16'd0},
    '{csg_pkg::OP_TICK,  16'sd0,      1'b0, 16'sd0,     16'sd0,      16'sd0,
      1'b0, 16'sd0, 16'sd0, 16'sd0, 16'd0},
    '{csg_pkg::OP_EMPTY, 16'sd0,      1'b0, 16'sd0,     16'sd0,      16'sd0,
      1'b0, 16'sd0, 16'sd0, 16'sd0, 16'd0},
    '{csg_pkg::OP_TICK,  16'sd0,      1'b0, 16'sd0,     16'sd0,      16'sd0,
      1'b0, 16'sd0, 16'sd0, 16'sd0, 16'd0},
    '{csg_pkg::OP_POINT, 16'sd256,    1'b1, 16'sd0,     16'sd0,      16'sd0,
      1'b0, 16'sd0, 16'sd0, 16'sd0, 16'd0},
    '{csg_pkg::OP_TICK,  16'sd0,      1'b0, 16'sd0,     16'sd0,      16'sd0,
      1'b0, 16'sd0, 16'sd0, 16'sd0, 16'd0},
    '{csg_pkg::OP_POINT, 16'sd0,      1'b1, 16'sd0,     16'sd0,      16'sd0,
      1'b0, 16'sd0, 16'sd0, 16'sd0, 16'd0},
    '{csg_pkg::OP_TICK,  16'sd0,      1'b0, 16'sd0,     16'sd0,      16'sd0,
      1'b0, 16'sd0, 16'sd0, 16'sd0, 16'd0},
    '{csg_pkg::OP_POINT, -16'sd300,   1'b0, 16'sd0,     16'sd0,      16'sd0,
      1'b0, 16'sd0, 16'sd0, 16'sd0, 16'd0},
    '{csg_pkg::OP_POINT, 16'sd5000,   1'b0, 16'sd0,     16'sd0,      16'sd0,
      1'b0, 16'sd0, 16'sd0, 16'sd0, 16'd0},
    '{csg_pkg::OP_POINT, 16'sd7,      1'b0, 16'sd0,     16'sd0,      16'sd0,
      1'b0, 16'sd0, 16'sd0, 16'sd0, 16'd0},
    '{csg_pkg::OP_POINT, 16'sd9000,   1'b1, 16'sd0,     16'sd0,      16'sd0,
      1'b0, 16'sd0, 16'sd0, 16'sd0, 16'd0},
    '{csg_pkg::OP_TICK,  16'sd0,      1'b0, 16'sd0,     16'sd0,      16'sd0,
      1'b0, 16'sd0, 16'sd0, 16'sd0, 16'd0}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_idx = '0;
  logic [15:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_op = '0;
  logic signed [15:0] in_curv = '0;
  logic in_last = 1'b0;
  logic signed [15:0] in_vx = '0;
  logic signed [15:0] in_vy = '0;
  logic signed [15:0] in_w = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_vx;
  logic signed [15:0] out_vy;
  logic signed [15:0] out_w;
  logic [15:0] out_scale;

  logic [10:0] win_reg;
  logic [15:0] brake_reg;
  logic [15:0] floor_reg;
  logic [15:0] smooth_reg;
  int unsigned pts_seen;
  int unsigned peak_mag;
  int unsigned scale_q15;
  bit cmd_held;
  logic signed [15:0] hold_vx;
  logic signed [15:0] hold_vy;
  logic signed [15:0] hold_w;

  governed_cmd_t expected_cmds[$];
  int mismatch_count = 0;
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  int rx_wait = 0;

  curvature_speed_governor u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .op_i           (in_op),
    .curvature_i    (in_curv),
    .last_point_i   (in_last),
    .vel_x_i        (in_vx),
    .vel_y_i        (in_vy),
    .yaw_rate_i     (in_w),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .out_vel_x_o    (out_vx),
    .out_vel_y_o    (out_vy),
    .out_yaw_rate_o (out_w),
    .speed_scale_o  (out_scale)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic signed [15:0] mul_round(input logic signed [15:0] v,
                                                  input int unsigned s);
    int sv;
    int unsigned mag;
    longint unsigned p;
    longint q;
    sv = v;
    mag = (sv < 0) ? -sv : sv;
    p = (64'(mag) * s + 64'd16384) >> 15;
    q = (sv < 0) ? -longint'(p) : longint'(p);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return 16'(q);
  endfunction

  function automatic bit govern_step(input governor_req_t r, output governed_cmd_t res);
    int unsigned lim, mag, gain, lo, root, t;
    int sv;
    longint unsigned den, target, acc, n, rem;
    bit emit;
    emit = 1'b0;
    res = '0;
    case (r.op)
      csg_pkg::OP_POINT: begin
        lim = (win_reg == 0) ? 1 : win_reg;
        if (lim > csg_pkg::MaxWindowDef) lim = csg_pkg::MaxWindowDef;
        if (pts_seen < lim) begin
          sv = r.curv;
          mag = (sv < 0) ? -sv : sv;
          if (mag > peak_mag) peak_mag = mag;
          pts_seen++;
        end
        if (r.last) begin
          den = 64'd65536 + 64'(brake_reg) * 64'(peak_mag);
          target = ((64'd1 << 31) + den / 2) / den;
          lo = (floor_reg > csg_pkg::ScaleOne) ? 32'(csg_pkg::ScaleOne) : 32'(floor_reg);
          gain = (smooth_reg > csg_pkg::ScaleOne) ? 32'(csg_pkg::ScaleOne) : 32'(smooth_reg);
          if (target > 64'(csg_pkg::ScaleOne)) target = 64'(csg_pkg::ScaleOne);
          if (target < 64'(lo)) target = 64'(lo);
          acc = 64'(scale_q15) * 64'(32'(csg_pkg::ScaleOne) - gain) + target * 64'(gain)
                + 64'd16384;
          scale_q15 = 32'(acc >> 15);
          if (scale_q15 > 32'(csg_pkg::ScaleOne)) scale_q15 = 32'(csg_pkg::ScaleOne);
          pts_seen = 0;
          peak_mag = 0;
        end
      end
      csg_pkg::OP_EMPTY: begin
        scale_q15 = 32'(csg_pkg::ScaleOne);
        pts_seen = 0;
        peak_mag = 0;
      end
      csg_pkg::OP_CMD: begin
        hold_vx = r.vx;
        hold_vy = r.vy;
        hold_w = r.w;
        cmd_held = 1'b1;
      end
      default: begin
        if (cmd_held) begin
          n = 64'(scale_q15) << 15;
          root = 0;
          for (int b = 15; b >= 0; b--) begin
            t = root | (32'd1 << b);
            if (64'(t) * 64'(t) <= n) root = t;
          end
          rem = n - 64'(root) * 64'(root);
          if (rem > 64'(root)) root++;
          if (root > 32'(csg_pkg::ScaleOne)) root = 32'(csg_pkg::ScaleOne);
          res.vx = mul_round(hold_vx, scale_q15);
          res.vy = mul_round(hold_vy, scale_q15);
          res.w = mul_round(hold_w, root);
          res.scale = 16'(scale_q15);
          emit = 1'b1;
        end
      end
    endcase
    return emit;
  endfunction

  function automatic logic signed [15:0] pick_curvature();
    int c;
    case ($urandom_range(0, 5))
      0: c = $urandom_range(0, 65535);
      1: c = -32768;
      2: c = 32767;
      3: c = 0;
      default: c = int'($urandom_range(0, 2047)) - 1024;
    endcase
    return 16'(c);
  endfunction

  function automatic governor_req_t random_req();
    governor_req_t r;
    r.op = 2'($urandom_range(0, 3));
    r.curv = 16'($urandom_range(0, 65535));
    r.last = 1'($urandom_range(0, 1));
    r.vx = 16'($urandom_range(0, 65535));
    r.vy = 16'($urandom_range(0, 65535));
    r.w = 16'($urandom_range(0, 65535));
    return r;
  endfunction

  task automatic drive_req(input governor_req_t r, input bit typed,
                           input governed_cmd_t typed_exp);
    int gap;
    governed_cmd_t res;
    gap = tx_quiet ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= r.op;
    in_curv <= r.curv;
    in_last <= r.last;
    in_vx <= r.vx;
    in_vy <= r.vy;
    in_w <= r.w;
    do @(posedge clk); while (in_stall);
    if (govern_step(r, res)) begin
      expected_cmds.insert(expected_cmds.size(), typed ? typed_exp : res);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic apply_settings(input gov_settings_t s);
    cfg_we <= 1'b1;
    cfg_idx <= csg_pkg::REG_WINDOW;
    cfg_wdata <= s.win;
    @(posedge clk);
    cfg_idx <= csg_pkg::REG_BRAKE_GAIN;
    cfg_wdata <= s.brake;
    @(posedge clk);
    cfg_idx <= csg_pkg::REG_MIN_SCALE;
    cfg_wdata <= s.floor;
    @(posedge clk);
    cfg_idx <= csg_pkg::REG_SMOOTH_GAIN;
    cfg_wdata <= s.smooth;
    @(posedge clk);
    cfg_we <= 1'b0;
    win_reg = s.win[10:0];
    brake_reg = s.brake;
    floor_reg = s.floor;
    smooth_reg = s.smooth;
    @(posedge clk);
  endtask

  task automatic run_chunk(inout int left);
    governor_req_t r;
    int sel, len, lim;
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      lim = (win_reg == 0) ? 1 : win_reg;
      if (lim > 16) lim = 16;
      len = $urandom_range(1, lim + 3);
      for (int k = 1; k <= len; k++) begin
        r = random_req();
        r.op = csg_pkg::OP_POINT;
        r.curv = pick_curvature();
        r.last = (k == len);
        drive_req(r, 1'b0, '0);
      end
      left -= len;
    end else begin
      r = random_req();
      if (sel < 55) r.op = csg_pkg::OP_CMD;
      else if (sel < 80) r.op = csg_pkg::OP_TICK;
      else if (sel < 87) r.op = csg_pkg::OP_EMPTY;
      drive_req(r, 1'b0, '0);
      left--;
    end
    if ($urandom_range(0, 19) == 0) tx_quiet = !tx_quiet;
  endtask

  always @(posedge clk) begin
    governed_cmd_t exp_c;
    if (out_valid && !out_stall) begin
      if (expected_cmds.size() == 0) begin
        $display("%0t unexpected result: vx %0d vy %0d yaw %0d scale %0d",
                 $time, out_vx, out_vy, out_w, out_scale);
        mismatch_count++;
      end else begin
        exp_c = expected_cmds.pop_front();
        if (out_vx !== exp_c.vx) begin
          $display("%0t out_vel_x expected %0d actual %0d", $time, exp_c.vx, out_vx);
          mismatch_count++;
        end
        if (out_vy !== exp_c.vy) begin
          $display("%0t out_vel_y expected %0d actual %0d", $time, exp_c.vy, out_vy);
          mismatch_count++;
        end
        if (out_w !== exp_c.w) begin
          $display("%0t out_yaw_rate expected %0d actual %0d", $time, exp_c.w, out_w);
          mismatch_count++;
        end
        if (out_scale !== exp_c.scale) begin
          $display("%0t speed_scale expected %0d actual %0d", $time, exp_c.scale, out_scale);
          mismatch_count++;
        end
      end
      if ($urandom_range(0, 15) == 0) rx_quiet = !rx_quiet;
      rx_wait = rx_quiet ? 0 : $urandom_range(0, 13);
    end else if (out_valid && rx_wait > 0) begin
      rx_wait--;
    end
    out_stall <= (rx_wait != 0);
  end

  initial begin
    #6_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    gov_settings_t plan [NumPhases];
    governor_req_t r;
    governed_cmd_t typed_exp;
    int left, c;

    plan[0] = '{16'd0, 16'd0, 16'd0, 16'd32768};
    plan[1] = '{16'd1, 16'd65535, 16'd0, 16'd32768};
    plan[2] = '{16'hFFFF, 16'd256, 16'd32768, 16'd0};
    plan[3] = '{16'd5, 16'd65535, 16'hFFFF, 16'hFFFF};
    plan[4] = '{16'd1024, 16'd64, 16'd4096, 16'd16384};
    plan[5] = '{16'd3, 16'd1000, 16'd1000, 16'd9000};
    for (int p = 6; p < NumPhases; p++) begin
      plan[p].win = 16'($urandom_range(1, 12));
      plan[p].brake = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 2047))
                                                 : 16'($urandom_range(0, 65535));
      plan[p].floor = 16'($urandom_range(0, 32768));
      plan[p].smooth = 16'($urandom_range(0, 32768));
    end

    win_reg = 11'd1;
    brake_reg = '0;
    floor_reg = '0;
    smooth_reg = csg_pkg::GainResetVal;
    pts_seen = 0;
    peak_mag = 0;
    scale_q15 = 32'(csg_pkg::ScaleOne);
    cmd_held = 1'b0;
    hold_vx = '0;
    hold_vy = '0;
    hold_w = '0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The first rows run with the reset settings, the rest with a short window.
    for (int i = 0; i < DirRows; i++) begin
      if (i == PartB) begin
        drain();
        apply_settings('{16'd3, 16'd256, 16'd8192, 16'd32768});
      end
      r = '{DirTable[i].op, DirTable[i].curv, DirTable[i].last,
            DirTable[i].vx, DirTable[i].vy, DirTable[i].w};
      typed_exp = '{DirTable[i].ex_vx, DirTable[i].ex_vy, DirTable[i].ex_w,
                    DirTable[i].ex_scale};
      drive_req(r, DirTable[i].typed, typed_exp);
    end

    for (int p = 0; p < NumPhases; p++) begin
      drain();
      apply_settings(plan[p]);
      tx_quiet = ($urandom_range(0, 3) == 0);
      if (plan[p].win == 16'd1024) begin
        // A full window, with a peak inside it and a larger one just past it.
        for (int k = 1; k <= LongProfile; k++) begin
          r = random_req();
          r.op = csg_pkg::OP_POINT;
          c = int'($urandom_range(0, 128)) - 64;
          r.curv = (k == 1000) ? 16'sd200 : (k == 1025) ? 16'sh8000 : 16'(c);
          r.last = (k == LongProfile);
          drive_req(r, 1'b0, '0);
        end
      end
      left = PhaseItems;
      while (left > 0) run_chunk(left);
    end
    drain();

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/csg_pkg.sv
hw/rtl/csg_unit.sv
hw/rtl/curvature_speed_governor.sv
hw/rtl/csg_checker.sv
bench/tb_top.sv
